FILE: rtl/core/dfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfpa_pkg;

   localparam int MaxFracDigits = 9;
   localparam int IntW  = 64;
   localparam int FracW = 30;
   localparam int PrecW = 4;
   localparam int OpW   = 3;
   localparam int ReqW  = 3;

   // request codes on req_type
   typedef enum logic [ReqW-1:0] {
      ReqLoad   = 3'd0,
      ReqClear  = 3'd1,
      ReqAdd    = 3'd2,
      ReqSub    = 3'd3,
      ReqMul    = 3'd4,
      ReqDiv    = 3'd5,
      ReqAssign = 3'd6
   } req_code_type;

   // pending operator codes
   typedef enum logic [OpW-1:0] {
      OpAssign = 3'd0,
      OpAdd    = 3'd1,
      OpSub    = 3'd2,
      OpMul    = 3'd3,
      OpDiv    = 3'd4
   } op_type;

   typedef struct packed {
      logic [ReqW-1:0]         code;
      logic signed [IntW-1:0]  whole;
      logic [FracW-1:0]        frac;
      logic [PrecW-1:0]        prec;
   } item_type;

   // 10^p for p in 0..MaxFracDigits
   function automatic logic [FracW-1:0] pow10(input logic [PrecW-1:0] p);
      logic [FracW-1:0] r;
      case (p)
         4'd0:    r = 30'd1;
         4'd1:    r = 30'd10;
         4'd2:    r = 30'd100;
         4'd3:    r = 30'd1000;
         4'd4:    r = 30'd10000;
         4'd5:    r = 30'd100000;
         4'd6:    r = 30'd1000000;
         4'd7:    r = 30'd10000000;
         4'd8:    r = 30'd100000000;
         4'd9:    r = 30'd1000000000;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dfpa_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module dfpa_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dfpa_pkg::item_type req_item,
   output logic                    s1_valid,
   output dfpa_pkg::item_type      s1_item,
   input  wire logic               s1_take
);
   import dfpa_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_ready = !valid_ff || s1_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (s1_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dfpa_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module dfpa_exec (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              s1_valid,
   input  wire dfpa_pkg::item_type                s1_item,
   output logic                                   s1_take,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [dfpa_pkg::IntW-1:0]       rsp_cur_int_out,
   output logic [dfpa_pkg::FracW-1:0]             rsp_cur_frac_out,
   output logic [dfpa_pkg::PrecW-1:0]             rsp_cur_prec_out,
   output logic [dfpa_pkg::OpW-1:0]               rsp_pending_op_out,
   output logic signed [dfpa_pkg::IntW-1:0]       rsp_in_int_out,
   output logic [dfpa_pkg::FracW-1:0]             rsp_in_frac_out,
   output logic [dfpa_pkg::PrecW-1:0]             rsp_in_prec_out,
   output logic                                   rsp_load_error
);
   import dfpa_pkg::*;

   localparam logic [PrecW-1:0] PrecReset = PrecW'(MaxFracDigits);

   // architectural state; it doubles as the result register
   logic signed [IntW-1:0] cur_int_ff, cur_int_in, in_int_ff, in_int_in;
   logic [FracW-1:0]       cur_frac_ff, cur_frac_in, in_frac_ff, in_frac_in;
   logic [PrecW-1:0]       cur_prec_ff, cur_prec_in, in_prec_ff, in_prec_in;
   op_type                 op_ff, op_in;
   logic                   err_ff, err_in;
   logic                   valid_ff, valid_in;

   // add/sub datapath
   logic [PrecW-1:0]       prec_max;
   logic [FracW-1:0]       lim;
   logic [2*FracW-1:0]     prod_a, prod_b;
   logic [FracW:0]         frac_a, frac_b, frac_sum, frac_dif;
   logic                   carry, borrow;
   logic [FracW:0]         add_frac, sub_frac;
   logic signed [IntW-1:0] add_int, sub_int;
   logic                   load_bad;

   assign s1_take = s1_valid && (!valid_ff || rsp_ready);

   always_comb begin
      prec_max = (cur_prec_ff > in_prec_ff) ? cur_prec_ff : in_prec_ff;
      lim      = pow10(prec_max);
      prod_a   = cur_frac_ff * pow10(prec_max - cur_prec_ff);
      prod_b   = in_frac_ff * pow10(prec_max - in_prec_ff);
      frac_a   = prod_a[FracW:0];
      frac_b   = prod_b[FracW:0];
      frac_sum = frac_a + frac_b;
      carry    = frac_sum >= {1'b0, lim};
      add_frac = carry ? frac_sum - {1'b0, lim} : frac_sum;
      add_int  = cur_int_ff + in_int_ff + {{(IntW-1){1'b0}}, carry};
      borrow   = frac_a < frac_b;
      frac_dif = frac_a - frac_b;
      sub_frac = borrow ? frac_dif + {1'b0, lim} : frac_dif;
      sub_int  = cur_int_ff - in_int_ff - {{(IntW-1){1'b0}}, borrow};
      load_bad = (s1_item.prec > PrecReset) || (s1_item.frac >= pow10(s1_item.prec));
   end

   always_comb begin
      cur_int_in  = cur_int_ff;
      cur_frac_in = cur_frac_ff;
      cur_prec_in = cur_prec_ff;
      in_int_in   = in_int_ff;
      in_frac_in  = in_frac_ff;
      in_prec_in  = in_prec_ff;
      op_in       = op_ff;
      err_in      = 1'b0;

      unique case (req_code_type'(s1_item.code))
         ReqLoad: begin
            if (load_bad) begin
               err_in = 1'b1;
            end else begin
               in_int_in  = s1_item.whole;
               in_frac_in = s1_item.frac;
               in_prec_in = s1_item.prec;
            end
         end
         ReqClear: begin
            in_int_in  = '0;
            in_frac_in = '0;
            in_prec_in = PrecReset;
         end
         ReqAdd, ReqSub, ReqMul, ReqDiv, ReqAssign: begin
            case (op_ff)
               OpAdd: begin
                  cur_int_in  = add_int;
                  cur_frac_in = add_frac[FracW-1:0];
                  cur_prec_in = prec_max;
               end
               OpSub: begin
                  cur_int_in  = sub_int;
                  cur_frac_in = sub_frac[FracW-1:0];
                  cur_prec_in = prec_max;
               end
               OpAssign: begin
                  cur_int_in  = in_int_ff;
                  cur_frac_in = in_frac_ff;
                  cur_prec_in = in_prec_ff;
               end
               default: begin
                  // multiply/divide keep the current value
               end
            endcase
            case (req_code_type'(s1_item.code))
               ReqAdd:  op_in = OpAdd;
               ReqSub:  op_in = OpSub;
               ReqMul:  op_in = OpMul;
               ReqDiv:  op_in = OpDiv;
               default: op_in = OpAssign;
            endcase
         end
         default: begin
            // unused code: no state change
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (s1_take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         err_ff      <= 1'b0;
         cur_int_ff  <= '0;
         cur_frac_ff <= '0;
         cur_prec_ff <= PrecReset;
         in_int_ff   <= '0;
         in_frac_ff  <= '0;
         in_prec_ff  <= PrecReset;
         op_ff       <= OpAssign;
      end else begin
         valid_ff <= valid_in;
         if (s1_take) begin
            err_ff      <= err_in;
            cur_int_ff  <= cur_int_in;
            cur_frac_ff <= cur_frac_in;
            cur_prec_ff <= cur_prec_in;
            in_int_ff   <= in_int_in;
            in_frac_ff  <= in_frac_in;
            in_prec_ff  <= in_prec_in;
            op_ff       <= op_in;
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_cur_int_out    = cur_int_ff;
   assign rsp_cur_frac_out   = cur_frac_ff;
   assign rsp_cur_prec_out   = cur_prec_ff;
   assign rsp_pending_op_out = op_ff;
   assign rsp_in_int_out     = in_int_ff;
   assign rsp_in_frac_out    = in_frac_ff;
   assign rsp_in_prec_out    = in_prec_ff;
   assign rsp_load_error     = err_ff;

endmodule

`default_nettype wire

FILE: rtl/core/decimal_fixed_point_accumulator_core.sv
// A req transfer reaches rsp_valid through the input register, then the state/result register.
// Throughput: one item per cycle while rsp_ready is high; the state update (align multiply,
// add, carry compare) is combinational in the execute stage, so no item waits on it.
// Reset: synchronous, active high; both values clear to 0 with precision 9,
// pending operator clears to assign, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module decimal_fixed_point_accumulator_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [dfpa_pkg::ReqW-1:0]      req_type,
   input  wire logic signed [dfpa_pkg::IntW-1:0] req_load_int,
   input  wire logic [dfpa_pkg::FracW-1:0]     req_load_frac,
   input  wire logic [dfpa_pkg::PrecW-1:0]     req_load_prec,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [dfpa_pkg::IntW-1:0]    rsp_cur_int_out,
   output logic [dfpa_pkg::FracW-1:0]          rsp_cur_frac_out,
   output logic [dfpa_pkg::PrecW-1:0]          rsp_cur_prec_out,
   output logic [dfpa_pkg::OpW-1:0]            rsp_pending_op_out,
   output logic signed [dfpa_pkg::IntW-1:0]    rsp_in_int_out,
   output logic [dfpa_pkg::FracW-1:0]          rsp_in_frac_out,
   output logic [dfpa_pkg::PrecW-1:0]          rsp_in_prec_out,
   output logic                                rsp_load_error
);
   import dfpa_pkg::*;

   item_type req_item;
   item_type s1_item;
   logic     s1_valid;
   logic     s1_take;

   // bundle the request fields into one item
   assign req_item.code  = req_type;
   assign req_item.whole = req_load_int;
   assign req_item.frac  = req_load_frac;
   assign req_item.prec  = req_load_prec;

   // stage 1: input register; it frees up whenever execute takes its item,
   // so transfers land every cycle while responses drain; a stalled response
   // lets one more item in here, then req_ready drops
   dfpa_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .s1_take   (s1_take)
   );

   // stage 2: execute; the state registers are the response payload, and they
   // only move when a new response is loaded, so a stalled response holds
   dfpa_exec u_exec (
      .clock              (clock),
      .reset              (reset),
      .s1_valid           (s1_valid),
      .s1_item            (s1_item),
      .s1_take            (s1_take),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cur_int_out    (rsp_cur_int_out),
      .rsp_cur_frac_out   (rsp_cur_frac_out),
      .rsp_cur_prec_out   (rsp_cur_prec_out),
      .rsp_pending_op_out (rsp_pending_op_out),
      .rsp_in_int_out     (rsp_in_int_out),
      .rsp_in_frac_out    (rsp_in_frac_out),
      .rsp_in_prec_out    (rsp_in_prec_out),
      .rsp_load_error     (rsp_load_error)
   );

endmodule

`default_nettype wire

FILE: rtl/core/dfpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dfpa_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_ready,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic signed [dfpa_pkg::IntW-1:0] rsp_cur_int_out,
   input  wire logic [dfpa_pkg::FracW-1:0]       rsp_cur_frac_out,
   input  wire logic [dfpa_pkg::PrecW-1:0]       rsp_cur_prec_out,
   input  wire logic [dfpa_pkg::OpW-1:0]         rsp_pending_op_out,
   input  wire logic [dfpa_pkg::FracW-1:0]       rsp_in_frac_out,
   input  wire logic [dfpa_pkg::PrecW-1:0]       rsp_in_prec_out
);
   import dfpa_pkg::*;

   // stalled response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cur_int_out)
         && $stable(rsp_cur_frac_out) && $stable(rsp_pending_op_out))
      else $error("response changed while stalled");

   // fractions stay below 10^precision after every operation
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cur_prec_out <= PrecW'(MaxFracDigits)
         && rsp_in_prec_out <= PrecW'(MaxFracDigits)
         && rsp_cur_frac_out < pow10(rsp_cur_prec_out)
         && rsp_in_frac_out < pow10(rsp_in_prec_out))
      else $error("fraction out of range for its precision");

   a_op_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pending_op_out <= OpW'(OpDiv))
      else $error("bad pending operator");

   // with the response side draining, input never backs up
   a_no_backup: assert property (@(posedge clock) disable iff (reset)
      rsp_ready && $past(rsp_ready) && !$past(reset) |-> req_ready)
      else $error("request stalled with response side ready");

endmodule

bind decimal_fixed_point_accumulator_core dfpa_checker u_dfpa_checker (.*);

`default_nettype wire
